[rtl/i2cps_pkg.sv]
package i2cps_pkg;

    // request limits and field widths
    localparam int unsigned MAX_LEN   = 512;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 3;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_AW      = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_KIND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHIP_SELECT = CFG_IDX_W'(1);

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
    localparam logic [1:0] ST_BAD_COUNT = 2'd2;

    // control byte pieces
    localparam logic [7:0] CTRL_BASE = 8'hA0;
    localparam logic [7:0] CTRL_RD   = 8'h01;

    typedef struct packed {
        logic        func;
        logic [15:0] start_address;
        logic [9:0]  byte_count;
    } request_t;

    typedef struct packed {
        logic [7:0] ctrl_byte;
        logic [7:0] addr_high;
        logic [7:0] addr_low;
        logic       addr_low_used;
        logic [9:0] chunk_length;
        logic [8:0] buffer_offset;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_ERR
    } job_class_t;

    typedef struct packed {
        job_class_t  job_class;
        logic [1:0]  status;
        logic [15:0] addr;
        logic [9:0]  count;
    } job_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WRITE,
        B_READ
    } back_state_t;

    // capacity - 1 for a part kind
    function automatic logic [15:0] cap_mask(input logic [2:0] kind);
        logic [16:0] cap;
        cap = 17'd512 << kind;
        return 16'(cap - 17'd1);
    endfunction

    // page size - 1 for a part kind
    function automatic logic [6:0] page_mask(input logic [2:0] kind);
        logic [6:0] m;
        case (kind) inside
            [3'd0:3'd2]: m = 7'h0F;
            [3'd3:3'd4]: m = 7'h1F;
            [3'd5:3'd6]: m = 7'h3F;
            default:     m = 7'h7F;
        endcase
        return m;
    endfunction

    // control byte with read flag clear
    function automatic logic [7:0] ctrl_of(input logic [2:0] kind, input logic [2:0] cs,
                                           input logic [15:0] addr);
        logic [7:0] mask;
        logic [7:0] c;
        case (kind)
            3'd0:    mask = 8'h02;
            3'd1:    mask = 8'h06;
            default: mask = 8'h0E;
        endcase
        if (kind <= 3'd2)
            c = CTRL_BASE | (8'(addr >> 7) & mask);
        else
            c = CTRL_BASE | {4'd0, cs, 1'b0};
        return c;
    endfunction

endpackage

[rtl/i2cps_front.sv]
module i2cps_front (
    input  logic               start,
    input  i2cps_pkg::request_t request,
    input  logic [2:0]         device_kind,
    input  logic               q_full,
    output logic               busy,
    output logic               push,
    output i2cps_pkg::job_t    job
);
    import i2cps_pkg::*;

    logic count_bad;
    logic addr_bad;

    // accept when the queue has room
    assign busy = q_full;
    assign push = start && !q_full;

    // classify the request
    assign count_bad = (request.byte_count == 10'd0) ||
                       (request.byte_count > 10'(MAX_LEN));
    assign addr_bad  = request.start_address > cap_mask(device_kind);

    always_comb
    begin
        job.addr  = request.start_address;
        job.count = request.byte_count;
        if (count_bad)
        begin
            job.job_class = JOB_ERR;
            job.status    = ST_BAD_COUNT;
        end
        else if (addr_bad)
        begin
            job.job_class = JOB_ERR;
            job.status    = ST_BAD_ADDR;
        end
        else
        begin
            job.job_class = request.func ? JOB_READ : JOB_WRITE;
            job.status    = ST_OK;
        end
    end

endmodule

[rtl/i2cps_queue.sv]
module i2cps_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cps_pkg::job_t job_in,
    input  logic            pop,
    output i2cps_pkg::job_t job_out,
    output logic            empty,
    output logic            full
);
    import i2cps_pkg::*;

    job_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign job_out = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job_in;
    end

endmodule

[rtl/i2cps_back.sv]
module i2cps_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         device_kind,
    input  logic [2:0]         chip_select,
    input  i2cps_pkg::job_t    job,
    input  logic               q_empty,
    output logic               pop,
    output logic               strobe,
    output i2cps_pkg::result_t result
);
    import i2cps_pkg::*;

    back_state_t state_reg, state_next;
    logic [15:0] addr_reg, addr_next;
    logic [9:0]  rem_reg, rem_next;
    logic [9:0]  off_reg, off_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic        strobe_reg, strobe_next;
    result_t     result_reg, result_next;

    logic [15:0] cur_addr;
    logic [9:0]  cur_rem;
    logic [9:0]  cur_off;
    logic [15:0] cmask;
    logic [6:0]  pmask;
    logic [7:0]  page_left;
    logic [9:0]  chunk;
    logic [9:0]  rem_after;
    logic [15:0] addr_after;
    logic [7:0]  ctrl_w;
    logic        two_byte;
    result_t     chunk_res;

    assign strobe = strobe_reg;
    assign result = result_reg;

    // working position: fresh job when idle, else the running one
    assign cur_addr = (state_reg == B_IDLE) ? job.addr  : addr_reg;
    assign cur_rem  = (state_reg == B_IDLE) ? job.count : rem_reg;
    assign cur_off  = (state_reg == B_IDLE) ? 10'd0     : off_reg;

    // chunk up to the end of the current page
    assign cmask      = cap_mask(device_kind);
    assign pmask      = page_mask(device_kind);
    assign page_left  = {1'b0, pmask} + 8'd1 - {1'b0, cur_addr[6:0] & pmask};
    assign chunk      = (cur_rem < 10'(page_left)) ? cur_rem : 10'(page_left);
    assign rem_after  = cur_rem - chunk;
    assign addr_after = (cur_addr + 16'(chunk)) & cmask;
    assign ctrl_w     = ctrl_of(device_kind, chip_select, cur_addr);
    assign two_byte   = (device_kind > 3'd2);

    // descriptor for the current position
    always_comb
    begin
        chunk_res               = '0;
        chunk_res.ctrl_byte     = ctrl_w & ~CTRL_RD;
        chunk_res.addr_high     = two_byte ? (cur_addr[15:8] & cmask[15:8]) : cur_addr[7:0];
        chunk_res.addr_low      = two_byte ? cur_addr[7:0] : 8'd0;
        chunk_res.addr_low_used = two_byte;
        chunk_res.chunk_length  = chunk;
        chunk_res.buffer_offset = cur_off[8:0];
        chunk_res.status        = ST_OK;
        chunk_res.last          = (rem_after == 10'd0);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        rem_next    = rem_reg;
        off_next    = off_reg;
        ctrl_next   = ctrl_reg;
        strobe_next = 1'b0;
        result_next = '0;
        pop         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop         = 1'b1;
                    strobe_next = 1'b1;
                    case (job.job_class)
                        JOB_ERR:
                        begin
                            result_next.status = job.status;
                            result_next.last   = 1'b1;
                        end
                        JOB_READ:
                        begin
                            result_next               = chunk_res;
                            result_next.chunk_length  = 10'd0;
                            result_next.buffer_offset = 9'd0;
                            result_next.last          = 1'b0;
                            ctrl_next                 = ctrl_w | CTRL_RD;
                            rem_next                  = job.count;
                            state_next                = B_READ;
                        end
                        JOB_WRITE:
                        begin
                            result_next = chunk_res;
                            addr_next   = addr_after;
                            rem_next    = rem_after;
                            off_next    = cur_off + chunk;
                            if (rem_after != 10'd0)
                                state_next = B_WRITE;
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            B_WRITE:
            begin
                strobe_next = 1'b1;
                result_next = chunk_res;
                addr_next   = addr_after;
                rem_next    = rem_after;
                off_next    = cur_off + chunk;
                if (rem_after == 10'd0)
                    state_next = B_IDLE;
            end
            B_READ:
            begin
                strobe_next              = 1'b1;
                result_next.ctrl_byte    = ctrl_reg;
                result_next.chunk_length = rem_reg;
                result_next.status       = ST_OK;
                result_next.last         = 1'b1;
                state_next               = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        rem_reg    <= rem_next;
        off_reg    <= off_next;
        ctrl_reg   <= ctrl_next;
        result_reg <= result_next;
    end

endmodule

[rtl/i2c_eeprom_page_transaction_splitter.sv]
// 24xx i2c eeprom transaction splitter
// request channel: a request (func, start_address, byte_count) is taken at a
//   clock edge with start high and busy low; busy is high while two requests
//   wait in the queue between the front classifier and the back sequencer
// result channel: each descriptor is shown for one cycle with strobe high;
//   the receiver must take it, there is no hold-off
// config: cfg_write, cfg_index, cfg_data write device_kind (index 0) and
//   chip_select (index 1); write only while no request is in flight
// latency: the first descriptor of a request appears one cycle after it is
//   taken when the sequencer is free
// throughput: one descriptor per cycle from the sequencer; a request costs
//   one cycle (bad count or address), two (read) or one per page chunk
//   (write, up to 33 for 512 bytes on 16-byte pages), with no idle cycle
//   between queued requests
// reset: queue empty, sequencer idle, both config registers cleared
module i2c_eeprom_page_transaction_splitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  i2cps_pkg::request_t                 request,
    output logic                                strobe,
    output i2cps_pkg::result_t                  result,
    input  logic                                cfg_write,
    input  logic [i2cps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cps_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import i2cps_pkg::*;

    logic [2:0] kind_reg, kind_next;
    logic [2:0] cs_reg, cs_next;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    job_t       job_in;
    job_t       job_out;

    // configuration registers
    always_comb
    begin
        kind_next = kind_reg;
        cs_next   = cs_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_DEVICE_KIND: kind_next = cfg_data;
                REG_CHIP_SELECT: cs_next   = cfg_data;
                default:         kind_next = kind_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 3'd0;
            cs_reg   <= 3'd0;
        end
        else
        begin
            kind_reg <= kind_next;
            cs_reg   <= cs_next;
        end
    end

    i2cps_front u_front (
        .start       (start),
        .request     (request),
        .device_kind (kind_reg),
        .q_full      (q_full),
        .busy        (busy),
        .push        (push),
        .job         (job_in)
    );

    i2cps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_out),
        .empty   (q_empty),
        .full    (q_full)
    );

    i2cps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .device_kind (kind_reg),
        .chip_select (cs_reg),
        .job         (job_out),
        .q_empty     (q_empty),
        .pop         (pop),
        .strobe      (strobe),
        .result      (result)
    );

endmodule

[rtl/i2cps_checker.sv]
module i2cps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                strobe,
    input i2cps_pkg::result_t  result
);
    import i2cps_pkg::*;

    // a failed request gives a single descriptor with zero control byte and length
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != ST_OK |-> result.last && result.ctrl_byte == 8'd0
            && result.chunk_length == 10'd0)
        else $error("error result not a clean single transfer");

    // descriptors of one request come on consecutive cycles
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("gap inside a request");

    // good descriptors carry the eeprom device code
    a_dev_code: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == ST_OK |-> result.ctrl_byte[7:4] == 4'hA)
        else $error("bad device code in control byte");

    // a read data transfer ends its request and sends no address
    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status == ST_OK && result.ctrl_byte[0] |->
            result.last && !result.addr_low_used)
        else $error("read data transfer malformed");

endmodule

bind i2c_eeprom_page_transaction_splitter i2cps_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);

[tb/i2c_eeprom_page_transaction_splitter_tb.sv]
`timescale 1ns / 100ps

module i2c_eeprom_page_transaction_splitter_tb;

    import i2cps_pkg::*;

    // request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned IDLE_PERCENT  = 17;
    localparam int unsigned PHASE_ITEMS   = 14;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STEADY_PHASE  = 3;

    // descriptors whose value is plain from the error rules
    localparam result_t BAD_COUNT_DESC = '{ctrl_byte: 8'h00, addr_high: 8'h00,
        addr_low: 8'h00, addr_low_used: 1'b0, chunk_length: 10'd0,
        buffer_offset: 9'd0, status: ST_BAD_COUNT, last: 1'b1};
    localparam result_t BAD_ADDR_DESC = '{ctrl_byte: 8'h00, addr_high: 8'h00,
        addr_low: 8'h00, addr_low_used: 1'b0, chunk_length: 10'd0,
        buffer_offset: 9'd0, status: ST_BAD_ADDR, last: 1'b1};

    typedef struct packed {
        request_t req;
        logic     has_desc;
        result_t  desc;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    request_t             request;
    logic                 strobe;
    result_t              result;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // testbench copy of the part configuration
    logic [2:0] part_kind;
    logic [2:0] part_select;

    result_t     pending_descs[$];
    stim_row_t   directed_rows[$];
    int unsigned mismatches;
    int unsigned cycles;
    bit          sender_idles;

    i2c_eeprom_page_transaction_splitter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .strobe    (strobe),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // control and address bytes for an address inside the capacity
    function automatic result_t address_fields(input int unsigned addr);
        result_t     d;
        int unsigned cap;
        int unsigned blk;
        d = '0;
        cap = 512 << part_kind;
        if (part_kind <= 3'd2)
        begin
            blk = (part_kind == 3'd0) ? 'h02 : ((part_kind == 3'd1) ? 'h06 : 'h0E);
            d.ctrl_byte = CTRL_BASE | 8'((addr >> 7) & blk);
            d.addr_high = 8'(addr);
        end
        else
        begin
            d.ctrl_byte     = CTRL_BASE | {4'd0, part_select, 1'b0};
            d.addr_high     = 8'((addr >> 8) & ((cap - 1) >> 8));
            d.addr_low      = 8'(addr);
            d.addr_low_used = 1'b1;
        end
        return d;
    endfunction

    // split one request into its i2c descriptors
    function automatic void split_request(input request_t r);
        result_t     d;
        int unsigned cap;
        int unsigned page;
        int unsigned addr;
        int unsigned rem;
        int unsigned chunk;
        int unsigned off;
        cap  = 512 << part_kind;
        page = (part_kind <= 3'd2) ? 16 : (part_kind <= 3'd4) ? 32 :
               (part_kind <= 3'd6) ? 64 : 128;
        d = '0;
        d.last = 1'b1;
        // bad count wins over bad address
        if (r.byte_count == 10'd0 || r.byte_count > MAX_LEN)
        begin
            d.status = ST_BAD_COUNT;
            pending_descs.push_back(d);
            return;
        end
        if (r.start_address >= cap)
        begin
            d.status = ST_BAD_ADDR;
            pending_descs.push_back(d);
            return;
        end
        // read: address-set write, then the data read
        if (r.func == FUNC_READ)
        begin
            d = address_fields(r.start_address);
            pending_descs.push_back(d);
            d.ctrl_byte     = d.ctrl_byte | CTRL_RD;
            d.addr_high     = 8'd0;
            d.addr_low      = 8'd0;
            d.addr_low_used = 1'b0;
            d.chunk_length  = r.byte_count;
            d.last          = 1'b1;
            pending_descs.push_back(d);
            return;
        end
        // write: chunks cut at page boundaries, address wraps at capacity
        addr = r.start_address;
        rem  = r.byte_count;
        off  = 0;
        while (rem > 0)
        begin
            chunk = page - (addr & (page - 1));
            if (chunk > rem)
                chunk = rem;
            rem = rem - chunk;
            d = address_fields(addr);
            d.chunk_length  = 10'(chunk);
            d.buffer_offset = 9'(off);
            d.last          = (rem == 0);
            pending_descs.push_back(d);
            off  = off + chunk;
            addr = (addr + chunk) & (cap - 1);
        end
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // descriptor check against the oldest pending one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            if (pending_descs.size() == 0)
            begin
                $error("descriptor with none pending: 0x%0h", result);
                mismatches++;
            end
            else
            begin
                want = pending_descs.pop_front();
                compare_field("ctrl_byte", want.ctrl_byte, result.ctrl_byte);
                compare_field("addr_high", want.addr_high, result.addr_high);
                compare_field("addr_low", want.addr_low, result.addr_low);
                compare_field("addr_low_used", want.addr_low_used, result.addr_low_used);
                compare_field("chunk_length", want.chunk_length, result.chunk_length);
                compare_field("buffer_offset", want.buffer_offset, result.buffer_offset);
                compare_field("status", want.status, result.status);
                compare_field("last", want.last, result.last);
            end
        end
    end

    task automatic add_directed(input logic func, input logic [15:0] addr,
                                input logic [9:0] count, input logic has_desc,
                                input result_t desc);
        stim_row_t row;
        row.req.func          = func;
        row.req.start_address = addr;
        row.req.byte_count    = count;
        row.has_desc          = has_desc;
        row.desc              = desc;
        directed_rows.push_back(row);
    endtask

    // one request transfer, with a random gap ahead of it when sender_idles is set
    task automatic send_request(input request_t r, input logic has_desc,
                                input result_t desc);
        if (sender_idles && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PERCENT);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (has_desc)
            pending_descs.push_back(desc);
        else
            split_request(r);
    endtask

    function automatic request_t random_request();
        request_t    r;
        int unsigned cap;
        int unsigned sel;
        cap = 512 << part_kind;
        r.func = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 8)
            r.byte_count = $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(513, 1023));
        else if (sel < 60)
            r.byte_count = 10'($urandom_range(1, 48));
        else if (sel < 85)
            r.byte_count = 10'($urandom_range(49, MAX_LEN));
        else
            r.byte_count = $urandom_range(0, 1) ? 10'd1 : 10'(MAX_LEN);
        sel = $urandom_range(0, 99);
        if (sel < 10)
            r.start_address = 16'($urandom_range(0, 65535));
        else if (sel < 25)
            r.start_address = 16'(cap - $urandom_range(1, 200));
        else
            r.start_address = 16'($urandom_range(0, cap - 1));
        return r;
    endfunction

    task automatic wait_drained();
        int unsigned n;
        n = 0;
        start <= 1'b0;
        while (pending_descs.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_part(input logic [2:0] kind, input logic [2:0] sel);
        cfg_write <= 1'b1;
        cfg_index <= REG_DEVICE_KIND;
        cfg_data  <= CFG_DAT_W'(kind);
        @(posedge clk);
        cfg_index <= REG_CHIP_SELECT;
        cfg_data  <= CFG_DAT_W'(sel);
        @(posedge clk);
        cfg_write <= 1'b0;
        part_kind   = kind;
        part_select = sel;
    endtask

    initial
    begin
        logic [2:0] kinds[8];
        logic [2:0] selects[8];
        request_t   r;
        kinds   = '{3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0};
        selects = '{3'd7, 3'd3, 3'd6, 3'd0, 3'd5, 3'd2, 3'd1, 3'd7};
        mismatches   = 0;
        cycles       = 0;
        sender_idles = 1'b1;
        part_kind    = 3'd0;
        part_select  = 3'd0;
        rst_n     = 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows on the reset part (24xx04, 512 bytes, 16-byte pages)
        add_directed(FUNC_WRITE, 16'h0000, 10'd0, 1'b1, BAD_COUNT_DESC);
        add_directed(FUNC_READ, 16'h0000, 10'd0, 1'b1, BAD_COUNT_DESC);
        add_directed(FUNC_WRITE, 16'h0000, 10'd513, 1'b1, BAD_COUNT_DESC);
        add_directed(FUNC_READ, 16'hFFFF, 10'd1023, 1'b1, BAD_COUNT_DESC);
        add_directed(FUNC_WRITE, 16'hFFFF, 10'd1, 1'b1, BAD_ADDR_DESC);
        add_directed(FUNC_READ, 16'h0200, 10'd5, 1'b1, BAD_ADDR_DESC);
        add_directed(FUNC_WRITE, 16'h8000, 10'd512, 1'b1, BAD_ADDR_DESC);
        add_directed(FUNC_WRITE, 16'h0000, 10'd1, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h01FF, 10'd1, 1'b0, '0);
        add_directed(FUNC_READ, 16'h0000, 10'd512, 1'b0, '0);
        add_directed(FUNC_READ, 16'h01FF, 10'd1, 1'b0, '0);
        add_directed(FUNC_READ, 16'h0080, 10'd300, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h0000, 10'd512, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h0001, 10'd512, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h01F8, 10'd40, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h000F, 10'd2, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h0100, 10'd16, 1'b0, '0);
        add_directed(FUNC_WRITE, 16'h0180, 10'd128, 1'b0, '0);
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].has_desc,
                         directed_rows[i].desc);
        wait_drained();

        // random requests over a spread of parts and chip selects
        for (int p = 0; p < 8; p++)
        begin
            program_part(kinds[p], selects[p]);
            sender_idles = (p != STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = random_request();
                send_request(r, 1'b0, '0);
            end
            wait_drained();
        end

        if (pending_descs.size() != 0)
        begin
            $error("%0d descriptors never arrived", pending_descs.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[i2c_eeprom_page_transaction_splitter.f]
rtl/i2cps_pkg.sv
rtl/i2cps_front.sv
rtl/i2cps_queue.sv
rtl/i2cps_back.sv
rtl/i2c_eeprom_page_transaction_splitter.sv
rtl/i2cps_checker.sv
tb/i2c_eeprom_page_transaction_splitter_tb.sv
